// ----- sv/rhc_pkg.sv -----
// ----------------------------------------------------------------------------
// rhc_pkg - shared types and constants for the RGB to HSL converter
// Pixel and result transaction types, hue sector codes and the divider
// stage record that travels down the quotient pipeline.
// ----------------------------------------------------------------------------
package rhc_pkg;

	// Field widths
	localparam int CHAN_W  = 8;
	localparam int HUE_W   = 15;
	localparam int FRAC_W  = 16;

	// Divider geometry: 24-bit dividends, 16 quotient bits, one bit a stage
	localparam int NUM_W     = 24;
	localparam int QUO_W     = 16;
	localparam int DIV_STEPS = QUO_W;

	// Hue scale: one sixth of the circle and the full circle in 1/64 degree
	localparam int HUE_SIXTH = 3840;
	localparam int HUE_FULL  = 6 * HUE_SIXTH;
	localparam int FRAC_ONE  = 65535;

	// Which channel holds the maximum, in priority order
	typedef enum logic [1:0] {
		SECT_RED,
		SECT_GREEN,
		SECT_BLUE
	} hue_sect_t;

	// Input transaction
	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} pixel_t;

	// Result transaction
	typedef struct packed {
		logic [HUE_W-1:0]  hue;
		logic [FRAC_W-1:0] saturation;
		logic [FRAC_W-1:0] lightness;
	} hsl_t;

	// Per-pixel values that ride along with the quotients
	typedef struct packed {
		logic              grey;
		logic              neg;
		hue_sect_t         sect;
		logic [FRAC_W-1:0] lightness;
	} side_t;

	// One stage of the two-lane restoring divider
	typedef struct packed {
		logic [NUM_W-1:0]  hue_rem;
		logic [QUO_W-1:0]  hue_quo;
		logic [CHAN_W-1:0] hue_den;
		logic [NUM_W-1:0]  sat_rem;
		logic [QUO_W-1:0]  sat_quo;
		logic [CHAN_W-1:0] sat_den;
		side_t             side;
	} div_stage_t;

endpackage

// ----- sv/rgb_to_hsl_convert_unit.sv -----
// ----------------------------------------------------------------------------
// rgb_to_hsl_convert_unit - RGB to HSL pixel converter
// Converts 8-bit RGB pixels to hue (1/64 degree), saturation and lightness
// (0.16 fractions) in a fully pipelined datapath.
// ----------------------------------------------------------------------------
// Usage:
//   Drive pixel and raise start; the transaction is taken at each rising
//   edge where start is high and busy is low. busy stays low, so a new
//   pixel may be presented every cycle.
//   Each result appears on result for one cycle with done high, in input
//   order. Throughput is one pixel per cycle.
//   Hue and saturation quotients come out of a 16-stage restoring
//   divider, one quotient bit per stage, with one stage of min/max in
//   front, one stage of scaling, and the output register after it.
//   The receiver cannot stall: done is a strobe and each result must be
//   taken in its cycle.
//   Reset clears all valid bits; pixels in flight are dropped and no
//   strobe follows until a new pixel is taken.
// ----------------------------------------------------------------------------
module rgb_to_hsl_convert_unit (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  rhc_pkg::pixel_t pixel,
	output logic            done,
	output rhc_pkg::hsl_t   result
);

	// Stage 1: extremes, sector and hue difference
	logic                       valid_s1;
	logic [rhc_pkg::CHAN_W-1:0] delta_s1;
	logic [rhc_pkg::CHAN_W:0]   sum_s1;
	logic signed [rhc_pkg::CHAN_W:0] diff_s1;
	rhc_pkg::hue_sect_t         sect_s1;

	logic [rhc_pkg::CHAN_W-1:0] mx;
	logic [rhc_pkg::CHAN_W-1:0] mn;
	rhc_pkg::hue_sect_t         sect;
	logic signed [rhc_pkg::CHAN_W:0] diff;
	logic                       accept;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Find max, min and the sector by red, green, blue priority
	always_comb begin
		mx = pixel.red;
		mn = pixel.red;
		if (pixel.green > mx) mx = pixel.green;
		if (pixel.blue > mx) mx = pixel.blue;
		if (pixel.green < mn) mn = pixel.green;
		if (pixel.blue < mn) mn = pixel.blue;
		if (pixel.red == mx) begin
			sect = rhc_pkg::SECT_RED;
			diff = $signed({1'b0, pixel.green}) - $signed({1'b0, pixel.blue});
		end else if (pixel.green == mx) begin
			sect = rhc_pkg::SECT_GREEN;
			diff = $signed({1'b0, pixel.blue}) - $signed({1'b0, pixel.red});
		end else begin
			sect = rhc_pkg::SECT_BLUE;
			diff = $signed({1'b0, pixel.red}) - $signed({1'b0, pixel.green});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		delta_s1 <= mx - mn;
		sum_s1   <= {1'b0, mx} + {1'b0, mn};
		diff_s1  <= diff;
		sect_s1  <= sect;
	end

	// Stage 2: lightness, divisors and dividends
	logic                valid_s2;
	rhc_pkg::div_stage_t div_s2;

	logic [rhc_pkg::CHAN_W:0]   sum_inv;
	logic [rhc_pkg::CHAN_W:0]   den_full;
	logic [rhc_pkg::CHAN_W:0]   diff_mag;
	logic [rhc_pkg::FRAC_W:0]   light_full;
	rhc_pkg::div_stage_t        div_nxt;

	always_comb begin
		sum_inv    = 9'd510 - sum_s1;
		den_full   = (sum_inv < sum_s1) ? sum_inv : sum_s1;
		diff_mag   = diff_s1[rhc_pkg::CHAN_W] ? 9'(-diff_s1) : 9'(diff_s1);
		light_full = 17'(sum_s1) * 17'd257;

		div_nxt                = '0;
		div_nxt.hue_rem        = rhc_pkg::NUM_W'(diff_mag) *
		                         rhc_pkg::NUM_W'(rhc_pkg::HUE_SIXTH);
		div_nxt.hue_den        = delta_s1;
		div_nxt.sat_rem        = rhc_pkg::NUM_W'(delta_s1) *
		                         rhc_pkg::NUM_W'(rhc_pkg::FRAC_ONE);
		div_nxt.sat_den        = den_full[rhc_pkg::CHAN_W-1:0];
		div_nxt.side.grey      = (delta_s1 == '0);
		div_nxt.side.neg       = diff_s1[rhc_pkg::CHAN_W];
		div_nxt.side.sect      = sect_s1;
		div_nxt.side.lightness = light_full[rhc_pkg::FRAC_W:1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		div_s2 <= div_nxt;
	end

	// Quotient pipeline
	logic                div_valid;
	rhc_pkg::div_stage_t div_out;

	rhc_div_pipe u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s2),
		.in_stage  (div_s2),
		.out_valid (div_valid),
		.out_stage (div_out)
	);

	// Final stage: floor the hue, add the sector offset, wrap the circle
	logic signed [16:0] hue_off;
	logic signed [16:0] hue_mag;
	logic signed [16:0] hue_val;
	rhc_pkg::hsl_t      res_nxt;
	rhc_pkg::hsl_t      result_q;
	logic               done_q;

	always_comb begin
		unique case (div_out.side.sect)
			rhc_pkg::SECT_RED:   hue_off = 17'sd0;
			rhc_pkg::SECT_GREEN: hue_off = 17'(2 * rhc_pkg::HUE_SIXTH);
			rhc_pkg::SECT_BLUE:  hue_off = 17'(4 * rhc_pkg::HUE_SIXTH);
			default:             hue_off = 17'sd0;
		endcase

		// Negative dividends round toward minus infinity
		hue_mag = $signed(17'(div_out.hue_quo));
		if (div_out.side.neg && (div_out.hue_rem != '0)) begin
			hue_mag = hue_mag + 17'sd1;
		end
		hue_val = div_out.side.neg ? (hue_off - hue_mag) : (hue_off + hue_mag);
		if (hue_val[16]) begin
			hue_val = hue_val + 17'(rhc_pkg::HUE_FULL);
		end

		res_nxt.lightness = div_out.side.lightness;
		if (div_out.side.grey) begin
			res_nxt.hue        = '0;
			res_nxt.saturation = '0;
		end else begin
			res_nxt.hue        = hue_val[rhc_pkg::HUE_W-1:0];
			res_nxt.saturation = div_out.sat_quo;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		result_q <= res_nxt;
	end

	assign done   = done_q;
	assign result = result_q;

	// Checks
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##19 done)
		else $error("result strobe missing 19 edges after accepted pixel");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 19))
		else $error("result strobe without an accepted pixel");

	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.hue < rhc_pkg::HUE_W'(rhc_pkg::HUE_FULL)))
		else $error("hue beyond full circle");

	a_grey: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(pixel.red == pixel.green && pixel.green == pixel.blue, 19)
		|-> (result.hue == '0) && (result.saturation == '0))
		else $error("grey pixel gave nonzero hue or saturation");

endmodule

// ----- sv/rhc_div_pipe.sv -----
// ----------------------------------------------------------------------------
// rhc_div_pipe - pipelined two-lane restoring divider
// Produces one quotient bit per stage for the hue and saturation lanes,
// most significant bit first. Valid bits travel with the data.
// ----------------------------------------------------------------------------
module rhc_div_pipe (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  rhc_pkg::div_stage_t in_stage,
	output logic                out_valid,
	output rhc_pkg::div_stage_t out_stage
);

	logic                valid_s [1:rhc_pkg::DIV_STEPS];
	rhc_pkg::div_stage_t stage_s [1:rhc_pkg::DIV_STEPS];

	for (genvar i = 0; i < rhc_pkg::DIV_STEPS; i++) begin : g_step
		localparam int BIT = rhc_pkg::DIV_STEPS - 1 - i;

		logic                      cur_valid;
		rhc_pkg::div_stage_t       cur;
		logic [rhc_pkg::NUM_W-1:0] hue_sub;
		logic [rhc_pkg::NUM_W-1:0] sat_sub;
		rhc_pkg::div_stage_t       nxt;

		// Stage zero is the incoming transaction
		if (i == 0) begin : g_head
			assign cur_valid = in_valid;
			assign cur       = in_stage;
		end else begin : g_body
			assign cur_valid = valid_s[i];
			assign cur       = stage_s[i];
		end

		// Try to subtract the shifted divisor in each lane
		always_comb begin
			hue_sub = rhc_pkg::NUM_W'(cur.hue_den) << BIT;
			sat_sub = rhc_pkg::NUM_W'(cur.sat_den) << BIT;
			nxt     = cur;
			if (cur.hue_rem >= hue_sub) begin
				nxt.hue_rem      = cur.hue_rem - hue_sub;
				nxt.hue_quo[BIT] = 1'b1;
			end
			if (cur.sat_rem >= sat_sub) begin
				nxt.sat_rem      = cur.sat_rem - sat_sub;
				nxt.sat_quo[BIT] = 1'b1;
			end
		end

		// Advance the valid bit
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[i+1] <= 1'b0;
			end else begin
				valid_s[i+1] <= cur_valid;
			end
		end

		// Advance the data
		always_ff @(posedge clk) begin
			stage_s[i+1] <= nxt;
		end
	end

	assign out_valid = valid_s[rhc_pkg::DIV_STEPS];
	assign out_stage = stage_s[rhc_pkg::DIV_STEPS];

endmodule
